// File: rtl/cfm_pkg.sv
// ----------------------------------------------------------------------------
// cfm_pkg
// Shared types, widths and constants of the clock frequency meter.
// ----------------------------------------------------------------------------
package cfm_pkg;

	localparam int COUNT_WIDTH_DEF = 32;

	localparam int REF_W   = 32;
	localparam int DEN_W   = 32;
	localparam int FREQ_W  = 32;
	localparam int WIN_W   = 16;
	localparam int RFREQ_W = 27;
	localparam int SPI_W   = 28;
	localparam int DIVR_W  = 16;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [WIN_W-1:0]   WINDOW_RST   = 16'd100;
	localparam logic [RFREQ_W-1:0] REF_FREQ_RST = 27'd32768;
	localparam logic [SPI_W-1:0]   SPI_MAX_RST  = 28'd50000000;

	typedef enum logic [1:0] {
		REG_WINDOW   = 2'd0,
		REG_REF_FREQ = 2'd1,
		REG_SPI_MAX  = 2'd2,
		REG_NONE     = 2'd3
	} cfm_reg_t;

	typedef enum logic [1:0] {
		DIV_OP_CYC = 2'd0,
		DIV_OP_LO  = 2'd1,
		DIV_OP_SPI = 2'd2,
		DIV_OP_NONE = 2'd3
	} cfm_div_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WAIT,
		ST_COUNT,
		ST_DQ_GO,
		ST_DQ_RUN,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_DL_GO,
		ST_DL_RUN,
		ST_SUM,
		ST_DS_GO,
		ST_DS_RUN,
		ST_OUT
	} cfm_state_t;

	typedef struct packed {
		logic        cap_first;
		logic        cap_start;
		logic        cnt_inc;
		logic        div_go;
		cfm_div_op_t div_op;
		logic        mul_hi;
		logic        mul_lo;
		logic        sum_ld;
		logic        out_ld;
	} cfm_cmd_t;

	typedef struct packed {
		logic ref_changed;
		logic window_hit;
		logic div_busy;
		logic div_done;
		logic out_free;
	} cfm_sts_t;

endpackage

// File: rtl/cfm_div.sv
// ----------------------------------------------------------------------------
// cfm_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfm_div #(
	parameter int NUM_W = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [NUM_W-1:0]         num,
	input  logic [cfm_pkg::DEN_W-1:0] den,
	output logic                     busy,
	output logic                     done,
	output logic [NUM_W-1:0]         quo,
	output logic [cfm_pkg::DEN_W-1:0] rem
);

	localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic [NUM_W-1:0]          quo_q;
	logic [cfm_pkg::DEN_W-1:0] rem_q;
	logic [cfm_pkg::DEN_W-1:0] den_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [cfm_pkg::DEN_W:0]   trial;
	logic [cfm_pkg::DEN_W:0]   diff;
	logic                      qbit;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = ~diff[cfm_pkg::DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[cfm_pkg::DEN_W-1:0] : trial[cfm_pkg::DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// File: rtl/cfm_datapath.sv
// ----------------------------------------------------------------------------
// cfm_datapath
// Reference capture, cycle counter, frequency arithmetic and result register.
// ----------------------------------------------------------------------------
module cfm_datapath #(
	parameter int COUNT_WIDTH = cfm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfm_pkg::cfm_cmd_t           cmd,
	output cfm_pkg::cfm_sts_t           sts,
	input  logic [cfm_pkg::REF_W-1:0]   ref_time,
	input  logic [cfm_pkg::WIN_W-1:0]   window_ticks,
	input  logic [cfm_pkg::RFREQ_W-1:0] ref_freq_hz,
	input  logic [cfm_pkg::SPI_W-1:0]   spi_max_hz,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cfm_pkg::FREQ_W-1:0]  cpu_freq_hz,
	output logic [cfm_pkg::DIVR_W-1:0]  spi_divider
);

	localparam int NUM_W = (COUNT_WIDTH > cfm_pkg::FREQ_W) ? COUNT_WIDTH : cfm_pkg::FREQ_W;
	localparam int MUL_W = cfm_pkg::FREQ_W + cfm_pkg::RFREQ_W;

	logic [cfm_pkg::REF_W-1:0]  first_ref_q;
	logic [cfm_pkg::REF_W-1:0]  start_ref_q;
	logic [COUNT_WIDTH-1:0]     cycle_cnt_q;
	logic [cfm_pkg::DEN_W-1:0]  ticks_q;
	logic [cfm_pkg::FREQ_W-1:0] hi_q;
	logic [cfm_pkg::FREQ_W-1:0] prod_q;
	logic [cfm_pkg::FREQ_W-1:0] freq_q;
	logic [cfm_pkg::FREQ_W-1:0] cpu_freq_q;
	logic [cfm_pkg::DIVR_W-1:0] spi_div_q;
	logic                       out_valid_q;

	logic [cfm_pkg::REF_W-1:0]  delta;
	logic [cfm_pkg::WIN_W-1:0]  win;
	logic [NUM_W-1:0]           div_num;
	logic [cfm_pkg::DEN_W-1:0]  div_den;
	logic [NUM_W-1:0]           quo;
	logic [cfm_pkg::DEN_W-1:0]  rem;
	logic                       div_busy;
	logic                       div_done;
	logic [cfm_pkg::SPI_W:0]    spi_p1;
	logic [cfm_pkg::FREQ_W-1:0] mul_a;
	logic [MUL_W-1:0]           mul_full;
	logic                       sat;

	assign delta = ref_time - start_ref_q;
	assign win   = (window_ticks == '0) ? cfm_pkg::WIN_W'(1) : window_ticks;

	assign spi_p1 = {1'b0, spi_max_hz} + (cfm_pkg::SPI_W + 1)'(1);

	always_comb begin
		case (cmd.div_op)
			cfm_pkg::DIV_OP_CYC: begin
				div_num = NUM_W'(cycle_cnt_q);
				div_den = ticks_q;
			end
			cfm_pkg::DIV_OP_LO: begin
				div_num = NUM_W'(prod_q);
				div_den = ticks_q;
			end
			cfm_pkg::DIV_OP_SPI: begin
				div_num = NUM_W'(freq_q);
				div_den = cfm_pkg::DEN_W'({spi_p1, 1'b0});
			end
			default: begin
				div_num = '0;
				div_den = ticks_q;
			end
		endcase
	end

	cfm_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo),
		.rem    (rem)
	);

	assign mul_a    = cmd.mul_lo ? rem : quo[cfm_pkg::FREQ_W-1:0];
	assign mul_full = MUL_W'(mul_a) * MUL_W'(ref_freq_hz);
	assign sat      = (quo[NUM_W-1:cfm_pkg::DIVR_W] != '0);

	always_ff @(posedge clk) begin
		if (cmd.cap_first) begin
			first_ref_q <= ref_time;
		end
		if (cmd.cap_start) begin
			start_ref_q <= ref_time;
			cycle_cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cycle_cnt_q <= cycle_cnt_q + COUNT_WIDTH'(1);
			ticks_q     <= delta;
		end
		if (cmd.mul_hi) begin
			hi_q <= mul_full[cfm_pkg::FREQ_W-1:0];
		end
		if (cmd.mul_lo) begin
			prod_q <= mul_full[cfm_pkg::FREQ_W-1:0];
		end
		if (cmd.sum_ld) begin
			freq_q <= hi_q + quo[cfm_pkg::FREQ_W-1:0];
		end
		if (cmd.out_ld) begin
			cpu_freq_q <= freq_q;
			spi_div_q  <= sat ? '1 : quo[cfm_pkg::DIVR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.ref_changed = (ref_time != first_ref_q);
	assign sts.window_hit  = (delta >= cfm_pkg::REF_W'(win));
	assign sts.div_busy    = div_busy;
	assign sts.div_done    = div_done;
	assign sts.out_free    = ~out_valid_q | ~out_stall;

	assign out_valid   = out_valid_q;
	assign cpu_freq_hz = cpu_freq_q;
	assign spi_divider = spi_div_q;

endmodule

// File: rtl/cfm_ctrl.sv
// ----------------------------------------------------------------------------
// cfm_ctrl
// Sequencer for measurement phases and the divide/multiply steps.
// ----------------------------------------------------------------------------
module cfm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  cfm_pkg::cfm_sts_t sts,
	output cfm_pkg::cfm_cmd_t cmd
);

	cfm_pkg::cfm_state_t state_q;
	cfm_pkg::cfm_state_t state_nxt;
	logic                acc;
	logic                stall;

	always_comb begin
		case (state_q)
			cfm_pkg::ST_IDLE,
			cfm_pkg::ST_WAIT,
			cfm_pkg::ST_COUNT: stall = 1'b0;
			default:           stall = 1'b1;
		endcase
	end

	assign in_stall = stall;
	assign acc      = in_valid & ~stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			cfm_pkg::ST_IDLE: begin
				if (acc && !kind) state_nxt = cfm_pkg::ST_WAIT;
			end
			cfm_pkg::ST_WAIT: begin
				if (acc && kind && sts.ref_changed) state_nxt = cfm_pkg::ST_COUNT;
			end
			cfm_pkg::ST_COUNT: begin
				if (acc && !kind) begin
					state_nxt = cfm_pkg::ST_WAIT;
				end else if (acc && sts.window_hit) begin
					state_nxt = cfm_pkg::ST_DQ_GO;
				end
			end
			cfm_pkg::ST_DQ_GO:  state_nxt = cfm_pkg::ST_DQ_RUN;
			cfm_pkg::ST_DQ_RUN: begin
				if (sts.div_done) state_nxt = cfm_pkg::ST_MUL_HI;
			end
			cfm_pkg::ST_MUL_HI: state_nxt = cfm_pkg::ST_MUL_LO;
			cfm_pkg::ST_MUL_LO: state_nxt = cfm_pkg::ST_DL_GO;
			cfm_pkg::ST_DL_GO:  state_nxt = cfm_pkg::ST_DL_RUN;
			cfm_pkg::ST_DL_RUN: begin
				if (sts.div_done) state_nxt = cfm_pkg::ST_SUM;
			end
			cfm_pkg::ST_SUM:    state_nxt = cfm_pkg::ST_DS_GO;
			cfm_pkg::ST_DS_GO:  state_nxt = cfm_pkg::ST_DS_RUN;
			cfm_pkg::ST_DS_RUN: begin
				if (sts.div_done) state_nxt = cfm_pkg::ST_OUT;
			end
			cfm_pkg::ST_OUT: begin
				if (sts.out_free) state_nxt = cfm_pkg::ST_IDLE;
			end
			default: state_nxt = cfm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_op = cfm_pkg::DIV_OP_CYC;
		case (state_q)
			cfm_pkg::ST_IDLE: begin
				cmd.cap_first = acc & ~kind;
			end
			cfm_pkg::ST_WAIT: begin
				cmd.cap_first = acc & ~kind;
				cmd.cap_start = acc & kind & sts.ref_changed;
			end
			cfm_pkg::ST_COUNT: begin
				cmd.cap_first = acc & ~kind;
				cmd.cnt_inc   = acc & kind;
			end
			cfm_pkg::ST_DQ_GO: begin
				cmd.div_go = 1'b1;
				cmd.div_op = cfm_pkg::DIV_OP_CYC;
			end
			cfm_pkg::ST_MUL_HI: cmd.mul_hi = 1'b1;
			cfm_pkg::ST_MUL_LO: cmd.mul_lo = 1'b1;
			cfm_pkg::ST_DL_GO: begin
				cmd.div_go = 1'b1;
				cmd.div_op = cfm_pkg::DIV_OP_LO;
			end
			cfm_pkg::ST_SUM: cmd.sum_ld = 1'b1;
			cfm_pkg::ST_DS_GO: begin
				cmd.div_go = 1'b1;
				cmd.div_op = cfm_pkg::DIV_OP_SPI;
			end
			cfm_pkg::ST_OUT: cmd.out_ld = sts.out_free;
			default: cmd.div_op = cfm_pkg::DIV_OP_CYC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: rtl/clock_frequency_meter_core.sv
// ----------------------------------------------------------------------------
// clock_frequency_meter_core
// Reciprocal frequency meter: counts local cycles over a reference window.
// ----------------------------------------------------------------------------
// While idle, while waiting for a reference edge and while counting, one
// sample beat is taken every cycle. When the reference has advanced by the
// window, the input stalls while a shared radix-2 divider (one quotient bit
// per cycle, dividend width the larger of COUNT_WIDTH and 32) runs three
// divisions and one multiplier runs two products, and it stays stalled until
// the result register is free. A finished result waits in its own register
// without blocking the next start beat.
module clock_frequency_meter_core #(
	parameter int COUNT_WIDTH = cfm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [cfm_pkg::REF_W-1:0]   ref_time,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cfm_pkg::FREQ_W-1:0]  cpu_freq_hz,
	output logic [cfm_pkg::DIVR_W-1:0]  spi_divider,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cfm_pkg::ADDR_W-1:0]  paddr,
	input  logic [cfm_pkg::DATA_W-1:0]  pwdata,
	output logic [cfm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	logic [cfm_pkg::WIN_W-1:0]   window_q;
	logic [cfm_pkg::RFREQ_W-1:0] ref_freq_q;
	logic [cfm_pkg::SPI_W-1:0]   spi_max_q;
	logic                        wr_en;
	cfm_pkg::cfm_reg_t           reg_sel;
	cfm_pkg::cfm_cmd_t           cmd;
	cfm_pkg::cfm_sts_t           sts;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = cfm_pkg::cfm_reg_t'(paddr[cfm_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= cfm_pkg::WINDOW_RST;
			ref_freq_q <= cfm_pkg::REF_FREQ_RST;
			spi_max_q  <= cfm_pkg::SPI_MAX_RST;
		end else if (wr_en) begin
			case (reg_sel)
				cfm_pkg::REG_WINDOW:   window_q   <= pwdata[cfm_pkg::WIN_W-1:0];
				cfm_pkg::REG_REF_FREQ: ref_freq_q <= pwdata[cfm_pkg::RFREQ_W-1:0];
				cfm_pkg::REG_SPI_MAX:  spi_max_q  <= pwdata[cfm_pkg::SPI_W-1:0];
				default:               window_q   <= window_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			cfm_pkg::REG_WINDOW:   prdata = cfm_pkg::DATA_W'(window_q);
			cfm_pkg::REG_REF_FREQ: prdata = cfm_pkg::DATA_W'(ref_freq_q);
			cfm_pkg::REG_SPI_MAX:  prdata = cfm_pkg::DATA_W'(spi_max_q);
			default:               prdata = '0;
		endcase
	end

	cfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfm_datapath #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.ref_time     (ref_time),
		.window_ticks (window_q),
		.ref_freq_hz  (ref_freq_q),
		.spi_max_hz   (spi_max_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cpu_freq_hz  (cpu_freq_hz),
		.spi_divider  (spi_divider)
	);

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !(out_valid && out_stall))
		else $error("result loaded over an unaccepted beat");

	a_div_idle_on_go: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |-> !sts.div_busy)
		else $error("divider restarted while busy");

	a_stall_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> in_stall)
		else $error("input taken during division");

	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_ld))
		else $error("result beat without load");

endmodule
